[design/life_pkg.sv]
// Shared types, constants and the next-generation rule for the toroidal life board.
// Used by life_cell, life_ctrl and life_automaton_torus; depends on nothing.
`default_nettype none

package life_pkg;

    // Board edge length default and fixed field widths
    localparam int GRID_SIZE_DEF = 64;
    localparam int COORD_W       = 6;
    localparam int FUNC_W        = 2;
    localparam int GEN_W         = 16;

    // Item function codes (code 3 does nothing)
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

    // Neighbour counts of the rule
    localparam logic [3:0] NBR_BIRTH = 4'd3;
    localparam logic [3:0] NBR_KEEP  = 4'd2;

    // Command broadcast from the controller to every row cell
    typedef struct packed {
        logic advance;   // replace every row by its next generation
        logic rot_row;   // take the row held by the next cell down the ring
        logic rot_col;   // rotate the row vector by one column
        logic wr_en;     // load bit 0 (only honoured at the head cell)
        logic wr_val;
    } cell_ctrl_t;

    // Next state of one cell from itself and its eight neighbours
    function automatic logic life_rule(input logic self, input logic [7:0] nbrs);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, nbrs[i]};
        end
        return (n == NBR_BIRTH) || ((n == NBR_KEEP) && self);
    endfunction

endpackage

`default_nettype wire

[design/life_cell.sv]
// One row cell of the board ring: holds a full board row, rotates it along the
// ring or along its columns, and computes its next generation. Uses life_pkg.
`default_nettype none

module life_cell #(
    parameter int GridSize = life_pkg::GRID_SIZE_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  life_pkg::cell_ctrl_t     cmd,
    input  wire  [GridSize-1:0]      up_row,    // row above on the torus
    input  wire  [GridSize-1:0]      down_row,  // row below, also the rotation source
    output logic [GridSize-1:0]      row_q
);

    logic [GridSize-1:0] row_reg;
    logic [GridSize-1:0] row_next;
    logic [GridSize-1:0] life_row;
    logic [GridSize-1:0] base_row;
    logic [GridSize-1:0] rot_row;

    // Next generation per column, neighbours wrap at the row ends
    for (genvar j = 0; j < GridSize; j++) begin : g_col
        localparam int L = (j == 0) ? GridSize - 1 : j - 1;
        localparam int R = (j == GridSize - 1) ? 0 : j + 1;
        assign life_row[j] = life_pkg::life_rule(row_reg[j],
            {up_row[L], up_row[j], up_row[R],
             row_reg[L], row_reg[R],
             down_row[L], down_row[j], down_row[R]});
        // column rotation: bit j takes bit j+1
        assign rot_row[j] = base_row[R];
    end

    // Next generation, or ring and column movement with a single-bit load at bit 0
    always_comb
    begin
        base_row = cmd.rot_row ? down_row : row_reg;
        row_next = cmd.rot_col ? rot_row : base_row;
        if (cmd.advance)
        begin
            row_next = life_row;
        end
        else if (cmd.wr_en)
        begin
            row_next[0] = cmd.wr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign row_q = row_reg;

endmodule

`default_nettype wire

[design/life_ctrl.sv]
// Item sequencer: takes one transfer, aligns the ring to the addressed cell,
// issues the cell command and holds the result register. Uses life_pkg.
`default_nettype none

module life_ctrl #(
    parameter int GridSize = life_pkg::GRID_SIZE_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cmd_valid,
    output logic                              cmd_ready,
    input  wire  [life_pkg::FUNC_W-1:0]       func,
    input  wire  [life_pkg::COORD_W-1:0]      row,
    input  wire  [life_pkg::COORD_W-1:0]      col,
    input  wire                               alive_in,
    output logic                              rsp_valid,
    input  wire                               rsp_ready,
    output logic                              cell_alive,
    output logic [life_pkg::GEN_W-1:0]        generation,
    input  wire                               head_bit,
    output life_pkg::cell_ctrl_t              cell_cmd
);

    localparam int IDX_W = (GridSize > 1) ? $clog2(GridSize) : 1;
    localparam int CW    = (IDX_W > life_pkg::COORD_W) ? IDX_W : life_pkg::COORD_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GridSize - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    logic [life_pkg::FUNC_W-1:0]   func_reg, func_next;
    logic [life_pkg::COORD_W-1:0]  row_reg, row_next;
    logic [life_pkg::COORD_W-1:0]  col_reg, col_next;
    logic                          alive_reg, alive_next;
    logic [IDX_W-1:0]              head_reg, head_next;   // logical row at cell 0
    logic [IDX_W-1:0]              coff_reg, coff_next;   // logical column at bit 0
    logic [life_pkg::GEN_W-1:0]    gen_reg, gen_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic                          cell_alive_reg, cell_alive_next;

    logic busy, on_board, row_hit, col_hit, rsp_free;
    logic is_wr, is_rd, is_adv, need_align, done;

    // Item decode and alignment
    always_comb
    begin
        busy       = (state_reg == ST_BUSY);
        on_board   = (int'(row_reg) < GridSize) && (int'(col_reg) < GridSize);
        row_hit    = (CW'(head_reg) == CW'(row_reg));
        col_hit    = (CW'(coff_reg) == CW'(col_reg));
        rsp_free   = !rsp_valid_reg || rsp_ready;
        is_wr      = (func_reg == life_pkg::FUNC_WRITE);
        is_rd      = (func_reg == life_pkg::FUNC_READ);
        is_adv     = (func_reg == life_pkg::FUNC_ADVANCE);
        need_align = (is_wr || is_rd) && on_board && !(row_hit && col_hit);
        done       = busy && rsp_free && !need_align;
    end

    // Command to the ring
    always_comb
    begin
        cell_cmd.advance = done && is_adv;
        cell_cmd.rot_row = busy && need_align && !row_hit;
        cell_cmd.rot_col = busy && need_align && !col_hit;
        cell_cmd.wr_en   = done && is_wr && on_board;
        cell_cmd.wr_val  = alive_reg;
    end

    // State, offsets, counter and result register
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        alive_next      = alive_reg;
        head_next       = head_reg;
        coff_next       = coff_reg;
        gen_next        = gen_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        cell_alive_next = cell_alive_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    func_next  = func;
                    row_next   = row;
                    col_next   = col;
                    alive_next = alive_in;
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (done)
                begin
                    state_next      = ST_IDLE;
                    rsp_valid_next  = 1'b1;
                    cell_alive_next = is_rd && on_board && head_bit;
                    if (is_adv)
                    begin
                        gen_next = gen_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cell_cmd.rot_row)
        begin
            head_next = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
        end
        if (cell_cmd.rot_col)
        begin
            coff_next = (coff_reg == IDX_LAST) ? '0 : coff_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            coff_reg      <= '0;
            gen_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            coff_reg      <= coff_next;
            gen_reg       <= gen_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        alive_reg      <= alive_next;
        cell_alive_reg <= cell_alive_next;
    end

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign cell_alive = cell_alive_reg;
    assign generation = gen_reg;

endmodule

`default_nettype wire

[design/life_automaton_torus.sv]
// Advance and unused codes finish without moving the ring; an on-board write or read first
// rotates the row ring and columns one step a cycle until the addressed cell sits at the
// head (rows and columns move together).
// Throughput: one item at a time; the next transfer is taken while a result waits.
// An advance updates every row of the board together. Reset clears the board to dead and
// the generation count to zero at once; there is no clearing pass.
// Top level; uses life_pkg, life_ctrl and life_cell.
`default_nettype none

module life_automaton_torus #(
    parameter int GridSize = life_pkg::GRID_SIZE_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cmd_valid,
    output logic                              cmd_ready,
    input  wire  [life_pkg::FUNC_W-1:0]       func,
    input  wire  [life_pkg::COORD_W-1:0]      row,
    input  wire  [life_pkg::COORD_W-1:0]      col,
    input  wire                               alive_in,
    output logic                              rsp_valid,
    input  wire                               rsp_ready,
    output logic                              cell_alive,
    output logic [life_pkg::GEN_W-1:0]        generation
);

    life_pkg::cell_ctrl_t  cell_cmd;
    logic [GridSize-1:0]   row_q [GridSize];

    // Sequencer
    life_ctrl #(
        .GridSize (GridSize)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .func       (func),
        .row        (row),
        .col        (col),
        .alive_in   (alive_in),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .cell_alive (cell_alive),
        .generation (generation),
        .head_bit   (row_q[0][0]),
        .cell_cmd   (cell_cmd)
    );

    // Ring of row cells; cell 0 is the head where loads and reads happen
    for (genvar i = 0; i < GridSize; i++) begin : g_row
        localparam int UP = (i == 0) ? GridSize - 1 : i - 1;
        localparam int DN = (i == GridSize - 1) ? 0 : i + 1;
        life_pkg::cell_ctrl_t cmd_i;

        always_comb
        begin
            cmd_i       = cell_cmd;
            cmd_i.wr_en = (i == 0) ? cell_cmd.wr_en : 1'b0;
        end

        life_cell #(
            .GridSize (GridSize)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd_i),
            .up_row   (row_q[UP]),
            .down_row (row_q[DN]),
            .row_q    (row_q[i])
        );
    end

endmodule

`default_nettype wire

[tb/sv/life_checker.sv]
// Scoreboard for the toroidal life board: watches both channels, keeps its own copy of the
// board and generation count, and compares every response transfer. Depends on life_pkg.
module life_checker
    import life_pkg::*;
#(
    parameter int GridSize = GRID_SIZE_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               cmd_valid,
    input  wire               cmd_ready,
    input  wire  [FUNC_W-1:0] func,
    input  wire  [COORD_W-1:0] row,
    input  wire  [COORD_W-1:0] col,
    input  wire               alive_in,
    input  wire               rsp_valid,
    input  wire               rsp_ready,
    input  wire               cell_alive,
    input  wire  [GEN_W-1:0]  generation,
    output int                errors,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit             alive;
        bit [GEN_W-1:0] gen;
    } cell_reply_t;

    // Shadow board and counter
    bit             life_board [GridSize][GridSize];
    bit [GEN_W-1:0] gen_count;
    cell_reply_t    reply_q[$];

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch on %s: got %0d, wanted %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Next generation of the whole board, computed from the old board only
    function automatic void step_board();
        int up;
        int dn;
        int lf;
        int rt;
        int n;
        bit nxt [GridSize][GridSize];
        for (int r = 0; r < GridSize; r++)
        begin
            up = (r + GridSize - 1) % GridSize;
            dn = (r + 1) % GridSize;
            for (int c = 0; c < GridSize; c++)
            begin
                lf = (c + GridSize - 1) % GridSize;
                rt = (c + 1) % GridSize;
                n = life_board[up][lf] + life_board[up][c] + life_board[up][rt]
                  + life_board[r][lf] + life_board[r][rt]
                  + life_board[dn][lf] + life_board[dn][c] + life_board[dn][rt];
                nxt[r][c] = (n == 3) || (n == 2 && life_board[r][c]);
            end
        end
        life_board = nxt;
        gen_count  = gen_count + 1'b1;
    endfunction

    // Apply one command to the shadow state and return the response it causes
    function automatic cell_reply_t predict_reply(input logic [FUNC_W-1:0] f,
                                                  input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c,
                                                  input logic a);
        cell_reply_t reply;
        bit on_board;
        on_board    = (r < GridSize) && (c < GridSize);
        reply.alive = 1'b0;
        if (f == FUNC_WRITE)
        begin
            if (on_board)
                life_board[r][c] = a;
        end
        else if (f == FUNC_ADVANCE)
        begin
            step_board();
        end
        else if (f == FUNC_READ)
        begin
            if (on_board)
                reply.alive = life_board[r][c];
        end
        reply.gen = gen_count;
        return reply;
    endfunction

    // Responses belong to earlier commands, so check before taking the new command
    always @(posedge clk or negedge rst_n)
    begin
        cell_reply_t want;
        if (!rst_n)
        begin
            foreach (life_board[r, c])
                life_board[r][c] = 1'b0;
            gen_count = '0;
            reply_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (reply_q.size() == 0)
                begin
                    report_mismatch("response with nothing pending", cell_alive, 0);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (cell_alive !== want.alive)
                        report_mismatch("cell_alive", cell_alive, want.alive);
                    if (generation !== want.gen)
                        report_mismatch("generation", generation, want.gen);
                end
            end
            if (cmd_valid && cmd_ready)
                reply_q.push_back(predict_reply(func, row, col, alive_in));
            outstanding <= reply_q.size();
        end
    end

endmodule

[tb/sv/tb_life_automaton_torus.sv]
// Top of the life board testbench: clock, reset, command stimulus and response stalls.
// Instantiates life_automaton_torus and life_checker; depends on life_pkg.
module tb_life_automaton_torus;
    timeunit 1ns;
    timeprecision 1ps;

    import life_pkg::*;

    localparam int GRID        = GRID_SIZE_DEF;
    localparam int LIMIT       = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = GRID + 8;
    localparam int PHASE_ITEMS = 22;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int IDLE_PCT  [4] = '{0, 86, 0, 28};
    localparam int STALL_PCT [4] = '{0, 0, 86, 28};

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cmd_valid  = 1'b0;
    logic               cmd_ready;
    logic [FUNC_W-1:0]  func       = FUNC_WRITE;
    logic [COORD_W-1:0] row        = '0;
    logic [COORD_W-1:0] col        = '0;
    logic               alive_in   = 1'b0;
    logic               rsp_valid;
    logic               rsp_ready  = 1'b0;
    logic               cell_alive;
    logic [GEN_W-1:0]   generation;

    int   errors;
    int   outstanding;
    int   cycle_count = 0;
    int   idle_pct    = 0;
    int   stall_pct   = 0;
    int   sent        = 0;
    int   hold_left   = 0;
    logic hold_req    = 1'b0;
    logic hold_seen   = 1'b0;

    always #1 clk = ~clk;

    life_automaton_torus #(.GridSize(GRID)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .func       (func),
        .row        (row),
        .col        (col),
        .alive_in   (alive_in),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .cell_alive (cell_alive),
        .generation (generation)
    );

    life_checker #(.GridSize(GRID)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .func        (func),
        .row         (row),
        .col         (col),
        .alive_in    (alive_in),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .cell_alive  (cell_alive),
        .generation  (generation),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Long receiver hold-off, started by toggling hold_req
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: random stalls plus the hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // One command transfer, with random idle cycles ahead of it
    task automatic issue_command(input logic [FUNC_W-1:0] f, input int r, input int c,
                                 input logic a);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        func      <= f;
        row       <= COORD_W'(r);
        col       <= COORD_W'(c);
        alive_in  <= a;
        do
            @(posedge clk);
        while (!cmd_ready);
        sent++;
    endtask

    task automatic random_command();
        issue_command(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, GRID - 1),
                      $urandom_range(0, GRID - 1), 1'($urandom_range(0, 1)));
    endtask

    // Seed a small wrapped window, run it a few generations, then read around it
    task automatic pattern_burst();
        int r0;
        int c0;
        r0 = $urandom_range(0, GRID - 1);
        c0 = $urandom_range(0, GRID - 1);
        repeat ($urandom_range(4, 8))
            issue_command(FUNC_WRITE, (r0 + $urandom_range(0, 3)) % GRID,
                          (c0 + $urandom_range(0, 3)) % GRID, $urandom_range(0, 99) < 75);
        repeat ($urandom_range(1, 3))
            issue_command(FUNC_ADVANCE, $urandom_range(0, GRID - 1),
                          $urandom_range(0, GRID - 1), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(3, 6))
            issue_command(FUNC_READ, (r0 + GRID - 1 + $urandom_range(0, 5)) % GRID,
                          (c0 + GRID - 1 + $urandom_range(0, 5)) % GRID,
                          1'($urandom_range(0, 1)));
    endtask

    // Stop offering and wait for every pending response
    task automatic wait_drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = IDLE_PCT[ph];
            stall_pct <= STALL_PCT[ph];
            if (ph == 0)
            begin
                // Empty board, then the four corners: one still block across the wrap
                issue_command(FUNC_READ, 0, 0, 1'b1);
                issue_command(FUNC_WRITE, 0, 0, 1'b1);
                issue_command(FUNC_WRITE, 0, GRID - 1, 1'b1);
                issue_command(FUNC_WRITE, GRID - 1, 0, 1'b1);
                issue_command(FUNC_WRITE, GRID - 1, GRID - 1, 1'b1);
                issue_command(FUNC_READ, GRID - 1, GRID - 1, 1'b0);
                issue_command(FUNC_ADVANCE, GRID - 1, GRID - 1, 1'b1);
                issue_command(FUNC_READ, 0, GRID - 1, 1'b1);
                // Unused code changes nothing
                issue_command(FUNC_SPARE, GRID - 1, GRID - 1, 1'b1);
                // Kill one corner; it is reborn from three wrapped neighbours
                issue_command(FUNC_WRITE, GRID - 1, GRID - 1, 1'b0);
                issue_command(FUNC_ADVANCE, 0, 0, 1'b0);
                issue_command(FUNC_READ, GRID - 1, GRID - 1, 1'b0);
                // Glider straddling the left/right edge
                issue_command(FUNC_WRITE, 30, GRID - 1, 1'b1);
                issue_command(FUNC_WRITE, 31, 0, 1'b1);
                issue_command(FUNC_WRITE, 32, GRID - 2, 1'b1);
                issue_command(FUNC_WRITE, 32, GRID - 1, 1'b1);
                issue_command(FUNC_WRITE, 32, 0, 1'b1);
                issue_command(FUNC_ADVANCE, 63, 63, 1'b1);
                issue_command(FUNC_ADVANCE, 0, 0, 1'b0);
                issue_command(FUNC_READ, 32, GRID - 1, 1'b0);
                issue_command(FUNC_READ, 33, GRID - 1, 1'b1);
                issue_command(FUNC_READ, 31, 0, 1'b0);
                // Hold the receiver off while commands keep coming
                hold_req <= ~hold_req;
                repeat (8)
                    issue_command(FUNC_READ, $urandom_range(0, GRID - 1),
                                  $urandom_range(0, GRID - 1), 1'($urandom_range(0, 1)));
            end
            target = sent + PHASE_ITEMS;
            while (sent < target)
            begin
                if ($urandom_range(0, 9) < 7)
                    pattern_burst();
                else
                    random_command();
            end
            wait_drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
design/life_pkg.sv
design/life_cell.sv
design/life_ctrl.sv
design/life_automaton_torus.sv
tb/sv/life_checker.sv
tb/sv/tb_life_automaton_torus.sv
